// ----- hw/rtl/sobel_edge_magnitude_unit_defines.svh -----
// assertion helpers shared by the sobel edge magnitude rtl
// each macro expects clk and arst_n in the scope where it is used
`ifndef SOBEL_EDGE_MAGNITUDE_UNIT_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define SEM_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// consequence holds in the same cycle as the antecedent
`define SEM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence holds in the cycle after the antecedent
`define SEM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/sem_pkg.sv -----
package sem_pkg;

	// configuration port
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 12;
	localparam int WIDTH_CFG_W  = 11;
	localparam int HEIGHT_CFG_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	localparam int MIN_DIM       = 3;
	localparam int WIDTH_RESET   = 640;
	localparam int HEIGHT_RESET  = 480;
	localparam int WIDTH_CFG_MAX = (1 << WIDTH_CFG_W) - 1;

	// result word fields
	localparam int OUT_ROW_W   = 12;
	localparam int OUT_COL_W   = 10;
	localparam int OUT_VALUE_W = 11;
	localparam int VALUE_MAX   = (1 << OUT_VALUE_W) - 1;

	// status of the square root unit
	typedef struct packed {
		logic busy;
		logic done;
	} sem_root_stat_t;

endpackage

// ----- hw/rtl/sem_ram.sv -----
module sem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/sem_isqrt.sv -----
module sem_isqrt #(
	parameter int IN_W = 21
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [IN_W-1:0]           operand,
	output logic [(IN_W+1)/2-1:0]     root,
	output sem_pkg::sem_root_stat_t   stat
);

	import sem_pkg::*;

	localparam int RT_W = (IN_W + 1) / 2;
	localparam int V_W  = 2 * RT_W;

	sem_root_stat_t stat_q;
	logic [V_W-1:0] v_q;
	logic [V_W-1:0] res_q;
	logic [V_W-1:0] bit_q;
	logic [V_W-1:0] trial;
	logic           fits;

	// one result bit per cycle, remainder kept in v_q
	assign trial = res_q + bit_q;
	assign fits  = (v_q >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q <= '0;
		end else begin
			stat_q.done <= 1'b0;
			if (start) begin
				stat_q.busy <= 1'b1;
			end else if (stat_q.busy && bit_q[0]) begin
				stat_q.busy <= 1'b0;
				stat_q.done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= V_W'(operand);
			res_q <= '0;
			bit_q <= {2'b01, {(V_W-2){1'b0}}};
		end else if (stat_q.busy) begin
			if (fits) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[RT_W-1:0];
	assign stat = stat_q;

endmodule

// ----- hw/rtl/sobel_edge_magnitude_unit.sv -----
// channel | handshake             | word
// --------+-----------------------+--------------------------------------------
// cfg     | cfg_write             | cfg_index, cfg_data (width 0, height 1)
// in      | in_valid / in_stall   | pixel_value
// out     | out_valid / out_stall | out_row, out_col, out_value, last_of_item
//
// one pixel at a time: read, then idle when it makes no word, border emit for a
// border-only word, or square, root and interior emit for an interior word (then
// border emit too when the pixel is on the border); one root bit per cycle
// the two line stores are plain rams with no reset and no clearing pass
// the output register lets the next pixel in while a word waits on out_stall
`include "sobel_edge_magnitude_unit_defines.svh"

module sobel_edge_magnitude_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [sem_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sem_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [PIXEL_BITS-1:0]             pixel_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [sem_pkg::OUT_ROW_W-1:0]     out_row,
	output logic [sem_pkg::OUT_COL_W-1:0]     out_col,
	output logic [sem_pkg::OUT_VALUE_W-1:0]   out_value,
	output logic                              last_of_item
);

	import sem_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int CMP_W = (CW > WIDTH_CFG_W) ? CW : WIDTH_CFG_W;
	localparam int S_W   = PIXEL_BITS + 2;     // weighted column sum
	localparam int SQ_W  = 2 * S_W + 1;        // gx^2 + gy^2
	localparam int RT_W  = (SQ_W + 1) / 2;
	localparam int SAT_W = (RT_W > OUT_VALUE_W) ? RT_W : OUT_VALUE_W;
	localparam logic [WIDTH_CFG_W-1:0] WIDTH_LIMIT =
		WIDTH_CFG_W'((MAX_WIDTH > WIDTH_CFG_MAX) ? WIDTH_CFG_MAX : MAX_WIDTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SQUARE,
		S_ROOT,
		S_EMIT_IN,
		S_EMIT_BD
	} state_t;

	state_t state_q;

	// configuration and raster position
	logic [WIDTH_CFG_W-1:0]  width_q;
	logic [HEIGHT_CFG_W-1:0] height_q;
	logic [CW-1:0]           col_q;
	logic [OUT_ROW_W-1:0]    row_q;

	// current pixel and where it sits
	logic [PIXEL_BITS-1:0]   pix_q;
	logic [CW-1:0]           item_col_q;
	logic [OUT_ROW_W-1:0]    item_row_q;
	logic                    border_q;

	// window: column c-2 (left) and column c-1 (center)
	logic [PIXEL_BITS-1:0]   win_tl_q, win_ml_q, win_bl_q;
	logic [PIXEL_BITS-1:0]   win_tc_q, win_mc_q, win_bc_q;

	// gradient magnitudes
	logic [S_W-1:0]          ax_q, ay_q;

	// output register
	logic                    out_valid_q;
	logic [OUT_ROW_W-1:0]    out_row_q;
	logic [OUT_COL_W-1:0]    out_col_q;
	logic [OUT_VALUE_W-1:0]  out_value_q;
	logic                    out_last_q;

	logic                    accept;
	logic                    out_free;
	logic [PIXEL_BITS-1:0]   top_rd, mid_rd;
	logic                    col_last, row_last;
	logic                    interior, border;
	logic [S_W-1:0]          sum_r, sum_l, sum_t, sum_b;
	logic [S_W-1:0]          gx_abs, gy_abs;
	logic [2*S_W-1:0]        sq_x, sq_y;
	logic [SQ_W-1:0]         sq_sum;
	logic                    root_start;
	logic [RT_W-1:0]         root;
	sem_root_stat_t          root_stat;
	logic [SAT_W-1:0]        pre_value;
	logic [OUT_VALUE_W-1:0]  sat_value;
	logic [WIDTH_CFG_W-1:0]  cfg_w;
	logic [WIDTH_CFG_W-1:0]  cfg_w_clamped;
	logic [HEIGHT_CFG_W-1:0] cfg_h;
	logic [HEIGHT_CFG_W-1:0] cfg_h_clamped;

	// one pixel in flight, taken only from idle
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// line stores: prev holds row r-1, prev2 row r-2; read on accept, written
	// back at the same column in the following cycle, next read is the next column
	sem_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_line_prev (
		.clk     (clk),
		.wr_en   (state_q == S_READ),
		.wr_addr (col_q),
		.wr_data (pix_q),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (mid_rd)
	);

	sem_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_line_prev2 (
		.clk     (clk),
		.wr_en   (state_q == S_READ),
		.wr_addr (col_q),
		.wr_data (mid_rd),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (top_rd)
	);

	// position checks, evaluated in the read cycle
	assign col_last = (CMP_W'(col_q) == CMP_W'(width_q) - CMP_W'(1));
	assign row_last = (row_q == height_q - HEIGHT_CFG_W'(1));
	assign interior = (row_q >= OUT_ROW_W'(2)) && (CMP_W'(col_q) >= CMP_W'(2));
	assign border   = (row_q == '0) || row_last || (col_q == '0) || col_last;

	// sobel kernels as weighted sums; only the absolute difference matters
	// because both gradients get squared
	assign sum_r  = S_W'(top_rd) + (S_W'(mid_rd) << 1) + S_W'(pix_q);
	assign sum_l  = S_W'(win_tl_q) + (S_W'(win_ml_q) << 1) + S_W'(win_bl_q);
	assign sum_t  = S_W'(win_tl_q) + (S_W'(win_tc_q) << 1) + S_W'(top_rd);
	assign sum_b  = S_W'(win_bl_q) + (S_W'(win_bc_q) << 1) + S_W'(pix_q);
	assign gx_abs = (sum_r >= sum_l) ? (sum_r - sum_l) : (sum_l - sum_r);
	assign gy_abs = (sum_t >= sum_b) ? (sum_t - sum_b) : (sum_b - sum_t);

	// squares feed the root unit's operand register directly
	assign sq_x       = ax_q * ax_q;
	assign sq_y       = ay_q * ay_q;
	assign sq_sum     = SQ_W'(sq_x) + SQ_W'(sq_y);
	assign root_start = (state_q == S_SQUARE);

	sem_isqrt #(
		.IN_W (SQ_W)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (root_start),
		.operand (sq_sum),
		.root    (root),
		.stat    (root_stat)
	);

	// magnitude or raw pixel, clipped to the output field
	assign pre_value = (state_q == S_EMIT_IN) ? SAT_W'(root) : SAT_W'(pix_q);
	assign sat_value = (pre_value > SAT_W'(VALUE_MAX)) ?
		OUT_VALUE_W'(VALUE_MAX) : OUT_VALUE_W'(pre_value);

	// register writes clamp to the legal frame size
	assign cfg_w = cfg_data[WIDTH_CFG_W-1:0];
	assign cfg_h = cfg_data[HEIGHT_CFG_W-1:0];
	assign cfg_w_clamped = (cfg_w < WIDTH_CFG_W'(MIN_DIM)) ? WIDTH_CFG_W'(MIN_DIM) :
		((cfg_w > WIDTH_LIMIT) ? WIDTH_LIMIT : cfg_w);
	assign cfg_h_clamped = (cfg_h < HEIGHT_CFG_W'(MIN_DIM)) ? HEIGHT_CFG_W'(MIN_DIM) : cfg_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			width_q     <= WIDTH_CFG_W'(WIDTH_RESET);
			height_q    <= HEIGHT_CFG_W'(HEIGHT_RESET);
			col_q       <= '0;
			row_q       <= '0;
			pix_q       <= '0;
			item_col_q  <= '0;
			item_row_q  <= '0;
			border_q    <= 1'b0;
			win_tl_q    <= '0;
			win_ml_q    <= '0;
			win_bl_q    <= '0;
			win_tc_q    <= '0;
			win_mc_q    <= '0;
			win_bc_q    <= '0;
			ax_q        <= '0;
			ay_q        <= '0;
			out_valid_q <= 1'b0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			out_value_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// word taken downstream
			if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pix_q   <= pixel_value;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					// line store data is here: shift window, latch gradients
					win_tl_q   <= win_tc_q;
					win_ml_q   <= win_mc_q;
					win_bl_q   <= win_bc_q;
					win_tc_q   <= top_rd;
					win_mc_q   <= mid_rd;
					win_bc_q   <= pix_q;
					ax_q       <= gx_abs;
					ay_q       <= gy_abs;
					item_col_q <= col_q;
					item_row_q <= row_q;
					border_q   <= border;
					// advance raster position
					if (col_last) begin
						col_q <= '0;
						row_q <= row_last ? '0 : row_q + OUT_ROW_W'(1);
					end else begin
						col_q <= col_q + CW'(1);
					end
					if (interior) begin
						state_q <= S_SQUARE;
					end else if (border) begin
						state_q <= S_EMIT_BD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SQUARE: begin
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (root_stat.done) begin
						state_q <= S_EMIT_IN;
					end
				end
				S_EMIT_IN: begin
					// interior word belongs to the window center (r-1, c-1)
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_row_q   <= item_row_q - OUT_ROW_W'(1);
						out_col_q   <= OUT_COL_W'(item_col_q - CW'(1));
						out_value_q <= sat_value;
						out_last_q  <= !border_q;
						state_q     <= border_q ? S_EMIT_BD : S_IDLE;
					end
				end
				S_EMIT_BD: begin
					// border pixel passes through as is
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_row_q   <= item_row_q;
						out_col_q   <= OUT_COL_W'(item_col_q);
						out_value_q <= sat_value;
						out_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// a write to width or height restarts the frame, line stores are kept
			if (cfg_write) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH: begin
						width_q <= cfg_w_clamped;
						col_q   <= '0;
						row_q   <= '0;
					end
					REG_IMAGE_HEIGHT: begin
						height_q <= cfg_h_clamped;
						col_q    <= '0;
						row_q    <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_row      = out_row_q;
	assign out_col      = out_col_q;
	assign out_value    = out_value_q;
	assign last_of_item = out_last_q;

	`SEM_ASSERT_ALWAYS(a_col_in_row, CMP_W'(col_q) < CMP_W'(width_q), "column past row end")
	`SEM_ASSERT_ALWAYS(a_row_in_frame, row_q < height_q, "row past frame end")
	`SEM_ASSERT_NEXT(a_accept_reads, accept, state_q == S_READ, "accepted pixel not read")
	`SEM_ASSERT_IMPL(a_root_start_free, root_start, !root_stat.busy, "root unit restarted busy")
	`SEM_ASSERT_IMPL(a_root_done_waited, root_stat.done, state_q == S_ROOT, "root done unexpected")

endmodule
